/* design/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg: shared types for the trial division factorizer
// Controller states, factor source select and the command / status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_START,
		S_DIV,
		S_DECIDE
	} state_t;

	// Source of the factor field of an emitted word
	typedef enum logic [1:0] {
		FACT_ZERO,
		FACT_TWO,
		FACT_DIV,
		FACT_REM
	} fact_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load;       // capture input value, reset divisor to 3
		logic      shift;      // divide remainder by two
		logic      div_start;  // launch remainder / divisor
		logic      take_quo;   // remainder <= quotient
		logic      step_div;   // divisor <= divisor + 2
		logic      emit;       // write output word
		fact_sel_t sel;
		logic      last;
		logic      no_factor;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic r_lt2;     // remainder is 0 or 1
		logic r_odd;
		logic r_is2;
		logic div_done;  // quotient and remainder valid this cycle
		logic d_gt_q;    // divisor above quotient: search is over
		logic rem_zero;  // divisor divides remainder
		logic out_free;  // output register can take a word
	} sts_t;

endpackage

`default_nettype wire

/* design/tdf_div.sv */
// ----------------------------------------------------------------------------
// tdf_div: restoring divider, one quotient bit per cycle
// done pulses for one cycle when the quotient and remainder are final.
// Outputs hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div #(
	parameter int VALUE_WIDTH = 31,
	parameter int DIV_WIDTH   = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [DIV_WIDTH-1:0]   divisor,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      quotient,
	output logic [DIV_WIDTH-1:0]        remainder
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIV_WIDTH:0]     trial;
	logic [DIV_WIDTH:0]     diff;
	logic                   fit;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[VALUE_WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		fit   = (trial >= {1'b0, divisor});
	end

	// Iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			cnt_q  <= CW'(VALUE_WIDTH);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fit};
			rem_q <= fit ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* design/tdf_dp.sv */
// ----------------------------------------------------------------------------
// tdf_dp: factorizer datapath
// Holds the remainder and the odd trial divisor, runs the shared divider
// and owns the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_dp #(
	parameter int VALUE_WIDTH = 31
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tdf_pkg::cmd_t          cmd,
	output tdf_pkg::sts_t               sts,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VALUE_WIDTH-1:0]      factor,
	output logic                        last,
	output logic                        no_factor
);

	// Trial divisor stays below 2**((VALUE_WIDTH+1)/2) + 2
	localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;

	logic [VALUE_WIDTH-1:0] r_q;
	logic [DW-1:0]          d_q;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] quo;
	logic [DW-1:0]          rem;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] factor_q;
	logic                   last_q;
	logic                   no_factor_q;
	logic [VALUE_WIDTH-1:0] fact_val;

	tdf_div #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIV_WIDTH   (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (r_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// Remainder and trial divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			d_q <= DW'(3);
		end else begin
			if (cmd.load) begin
				r_q <= value;
				d_q <= DW'(3);
			end else begin
				if (cmd.shift)
					r_q <= r_q >> 1;
				else if (cmd.take_quo)
					r_q <= quo;
				if (cmd.step_div)
					d_q <= d_q + DW'(2);
			end
		end
	end

	// Select the factor to emit
	always_comb begin
		case (cmd.sel)
			tdf_pkg::FACT_ZERO: fact_val = '0;
			tdf_pkg::FACT_TWO:  fact_val = VALUE_WIDTH'(2);
			tdf_pkg::FACT_DIV:  fact_val = VALUE_WIDTH'(d_q);
			tdf_pkg::FACT_REM:  fact_val = r_q;
			default:            fact_val = '0;
		endcase
	end

	// Output word register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			factor_q    <= fact_val;
			last_q      <= cmd.last;
			no_factor_q <= cmd.no_factor;
		end
	end

	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign last      = last_q;
	assign no_factor = no_factor_q;

	// Status back to the controller
	always_comb begin
		sts.r_lt2    = (r_q < VALUE_WIDTH'(2));
		sts.r_odd    = r_q[0];
		sts.r_is2    = (r_q == VALUE_WIDTH'(2));
		sts.div_done = div_done;
		sts.d_gt_q   = (VALUE_WIDTH'(d_q) > quo);
		sts.rem_zero = (rem == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	// Trial divisor is always odd
	a_d_odd: assert property (@(posedge clk) disable iff (!arst_n) d_q[0])
		else $error("trial divisor became even");

endmodule

`default_nettype wire

/* design/tdf_ctrl.sv */
// ----------------------------------------------------------------------------
// tdf_ctrl: factorizer controller
// Sequences the halving of even values, the odd trial divisions and the
// emission of each factor word, stalling while the output word is held.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tdf_pkg::sts_t sts,
	output tdf_pkg::cmd_t      cmd
);

	tdf_pkg::state_t state_q;
	tdf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tdf_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdf_pkg::S_IDLE: begin
				if (in_valid)
					state_d = tdf_pkg::S_CHECK;
			end
			tdf_pkg::S_CHECK: begin
				if (sts.r_lt2) begin
					if (sts.out_free)
						state_d = tdf_pkg::S_IDLE;
				end else if (!sts.r_odd) begin
					if (sts.out_free && sts.r_is2)
						state_d = tdf_pkg::S_IDLE;
				end else begin
					state_d = tdf_pkg::S_START;
				end
			end
			tdf_pkg::S_START: state_d = tdf_pkg::S_DIV;
			tdf_pkg::S_DIV: begin
				if (sts.div_done)
					state_d = tdf_pkg::S_DECIDE;
			end
			tdf_pkg::S_DECIDE: begin
				if (sts.d_gt_q) begin
					if (sts.out_free)
						state_d = tdf_pkg::S_IDLE;
				end else if (sts.rem_zero) begin
					if (sts.out_free)
						state_d = tdf_pkg::S_START;
				end else begin
					state_d = tdf_pkg::S_START;
				end
			end
			default: state_d = tdf_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		cmd.sel  = tdf_pkg::FACT_ZERO;
		in_ready = 1'b0;
		case (state_q)
			tdf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			tdf_pkg::S_CHECK: begin
				if (sts.r_lt2) begin
					cmd.emit      = sts.out_free;
					cmd.sel       = tdf_pkg::FACT_ZERO;
					cmd.last      = 1'b1;
					cmd.no_factor = 1'b1;
				end else if (!sts.r_odd) begin
					cmd.emit  = sts.out_free;
					cmd.shift = sts.out_free;
					cmd.sel   = tdf_pkg::FACT_TWO;
					cmd.last  = sts.r_is2;
				end
			end
			tdf_pkg::S_START: cmd.div_start = 1'b1;
			tdf_pkg::S_DIV: ;
			tdf_pkg::S_DECIDE: begin
				if (sts.d_gt_q) begin
					// remaining cofactor is the largest prime
					cmd.emit = sts.out_free;
					cmd.sel  = tdf_pkg::FACT_REM;
					cmd.last = 1'b1;
				end else if (sts.rem_zero) begin
					cmd.emit     = sts.out_free;
					cmd.take_quo = sts.out_free;
					cmd.sel      = tdf_pkg::FACT_DIV;
				end else begin
					cmd.step_div = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Never overwrite a held output word
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while output word is held");

	// Divider launches only from a stable remainder and divisor
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.take_quo && !cmd.step_div && !cmd.shift && !cmd.load)
		else $error("divider started while operands change");

	// A launched division is followed by the wait state
	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == tdf_pkg::S_DIV)
		else $error("division started without waiting");

endmodule

`default_nettype wire

/* design/trial_division_factorizer.sv */
// A value 2**k*m is first halved k times, then the odd part goes through
// trial divisions in the shared bit-serial divider. Worst case is a prime
// near 2**VALUE_WIDTH: about sqrt(value)/2 divisions.
// One value is worked on at a time.
// Reset (arst_n low) returns the controller to idle and drops any output word.
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Emits the prime factors of each input value in ascending order, repeated
// by multiplicity, with last on the final word; 0 and 1 give one no_factor word.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
	parameter int VALUE_WIDTH = 31
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VALUE_WIDTH-1:0]      factor,
	output logic                        last,
	output logic                        no_factor
);

	tdf_pkg::cmd_t cmd;
	tdf_pkg::sts_t sts;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdf_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.factor    (factor),
		.last      (last),
		.no_factor (no_factor)
	);

endmodule

`default_nettype wire
